// ===== rtl/core/pcg_rxs_pkg.sv =====
// shared types and constants of the pcg rxs-m-xs random generator
`timescale 1ns / 1ps

package pcg_rxs_pkg;

  localparam int WORD_W    = 64;
  localparam int HALF_W    = WORD_W / 2;
  localparam int DIV_CNT_W = $clog2(WORD_W);
  localparam int ROT_W     = 5;

  // lcg and output permutation constants
  localparam logic [WORD_W-1:0] LCG_MULT  = 64'h5851_F42D_4C95_7F2D;
  localparam logic [WORD_W-1:0] LCG_INC   = 64'h1405_7B7E_F767_814F;
  localparam logic [WORD_W-1:0] OUT_MULT  = 64'hAEF1_7502_108E_F2D9;
  localparam int                ROT_SHIFT   = 59;
  localparam int                BASE_SHIFT  = 5;
  localparam int                FINAL_SHIFT = 43;

  // request kinds
  localparam logic KIND_RAW     = 1'b0;
  localparam logic KIND_UNIFORM = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LCG_LL,
    ST_LCG_HL,
    ST_LCG_LH,
    ST_OUT_LL,
    ST_OUT_HL,
    ST_OUT_LH,
    ST_DIV,
    ST_FIN
  } ctrl_state_t;

  // which 32x32 partial product the shared multiplier forms
  typedef enum logic [1:0] {
    MP_LL,
    MP_HL,
    MP_LH
  } mul_phase_t;

  // which 64-bit product is being built
  typedef enum logic {
    SRC_LCG,
    SRC_OUT
  } mul_src_t;

  typedef struct packed {
    logic       accept;
    logic       seed_ld;
    logic       mul_en;
    mul_phase_t mul_phase;
    mul_src_t   mul_src;
    logic       rem_clr;
    logic       div_step;
    logic       load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic kind;
    logic range_zero;
  } dp_sts_t;

endpackage

// ===== rtl/core/pcg_rxs_req_if.sv =====
// request channel interface of the pcg rxs-m-xs random generator
`timescale 1ns / 1ps

interface pcg_rxs_req_if;
  logic                            valid;
  logic                            ready;
  logic                            kind;
  logic [pcg_rxs_pkg::WORD_W-1:0]  min_value;
  logic [pcg_rxs_pkg::WORD_W-1:0]  max_value;

  modport source (output valid, output kind, output min_value, output max_value,
                  input ready);
  modport sink   (input valid, input kind, input min_value, input max_value,
                  output ready);
endinterface

// ===== rtl/core/pcg_rxs_rsp_if.sv =====
// result channel interface of the pcg rxs-m-xs random generator
`timescale 1ns / 1ps

interface pcg_rxs_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [pcg_rxs_pkg::WORD_W-1:0]  value;
  logic                            range_error;

  modport source (output valid, output value, output range_error, input ready);
  modport sink   (input valid, input value, input range_error, output ready);
endinterface

// ===== rtl/core/pcg_rxs_dp.sv =====
// datapath: lcg state, shared 32x32 multiplier, bit-serial remainder, result word
`timescale 1ns / 1ps

module pcg_rxs_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pcg_rxs_pkg::dp_cmd_t            cmd,
  output pcg_rxs_pkg::dp_sts_t            sts,
  input  logic                            in_kind,
  input  logic [pcg_rxs_pkg::WORD_W-1:0]  in_min_value,
  input  logic [pcg_rxs_pkg::WORD_W-1:0]  in_max_value,
  input  logic [pcg_rxs_pkg::WORD_W-1:0]  cfg_wdata,
  output logic [pcg_rxs_pkg::WORD_W-1:0]  out_value,
  output logic                            out_range_error
);

  localparam int W = pcg_rxs_pkg::WORD_W;
  localparam int H = pcg_rxs_pkg::HALF_W;

  logic [W-1:0] state_r, state_nxt;
  logic [W-1:0] w_r, w_nxt;
  logic [W-1:0] acc_r, acc_nxt;
  logic [W-1:0] word_r, word_nxt;
  logic [W-1:0] rem_r, rem_nxt;
  logic [W-1:0] min_r, min_nxt;
  logic [W-1:0] range_r, range_nxt;
  logic         kind_r, kind_nxt;
  logic         range_zero_r, range_zero_nxt;
  logic [W-1:0] value_r, value_nxt;
  logic         err_r, err_nxt;

  logic [pcg_rxs_pkg::ROT_W-1:0] rot;
  logic [5:0]                    xs_amt;
  logic [W-1:0]                  permuted;
  logic [W-1:0]                  mul_a, mul_b;
  logic [H-1:0]                  mul_x, mul_y;
  logic [W-1:0]                  prod;
  logic [W-1:0]                  mul_sum;
  logic [W:0]                    div_t;

  // xorshift of the old state, shift set by its top bits
  always_comb begin
    rot      = state_r[W-1 -: pcg_rxs_pkg::ROT_W];
    xs_amt   = 6'(pcg_rxs_pkg::BASE_SHIFT) + 6'(rot);
    permuted = state_r ^ (state_r >> xs_amt);
  end

  // shared multiplier operand selection
  always_comb begin
    mul_a = (cmd.mul_src == pcg_rxs_pkg::SRC_OUT) ? w_r : state_r;
    mul_b = (cmd.mul_src == pcg_rxs_pkg::SRC_OUT) ? pcg_rxs_pkg::OUT_MULT
                                                   : pcg_rxs_pkg::LCG_MULT;
    unique case (cmd.mul_phase)
      pcg_rxs_pkg::MP_LL: begin
        mul_x = mul_a[H-1:0];
        mul_y = mul_b[H-1:0];
      end
      pcg_rxs_pkg::MP_HL: begin
        mul_x = mul_a[W-1:H];
        mul_y = mul_b[H-1:0];
      end
      pcg_rxs_pkg::MP_LH: begin
        mul_x = mul_a[H-1:0];
        mul_y = mul_b[W-1:H];
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
    prod    = W'(mul_x) * W'(mul_y);
    mul_sum = acc_r + {prod[H-1:0], {H{1'b0}}};
  end

  // one restoring remainder step
  assign div_t = {rem_r, word_r[W-1]};

  // next-state logic of the datapath registers
  always_comb begin
    state_nxt      = state_r;
    w_nxt          = w_r;
    acc_nxt        = acc_r;
    word_nxt       = word_r;
    rem_nxt        = rem_r;
    min_nxt        = min_r;
    range_nxt      = range_r;
    kind_nxt       = kind_r;
    range_zero_nxt = range_zero_r;
    value_nxt      = value_r;
    err_nxt        = err_r;

    if (cmd.seed_ld) begin
      state_nxt = cfg_wdata + pcg_rxs_pkg::LCG_INC;
    end

    if (cmd.accept) begin
      w_nxt          = permuted;
      kind_nxt       = in_kind;
      min_nxt        = in_min_value;
      range_nxt      = in_max_value - in_min_value;
      range_zero_nxt = (in_max_value == in_min_value);
    end

    if (cmd.mul_en) begin
      unique case (cmd.mul_phase)
        pcg_rxs_pkg::MP_LL: acc_nxt = prod;
        pcg_rxs_pkg::MP_HL: acc_nxt = mul_sum;
        pcg_rxs_pkg::MP_LH: begin
          if (cmd.mul_src == pcg_rxs_pkg::SRC_LCG) begin
            state_nxt = mul_sum + pcg_rxs_pkg::LCG_INC;
          end else begin
            word_nxt = mul_sum ^ (mul_sum >> pcg_rxs_pkg::FINAL_SHIFT);
          end
        end
        default: acc_nxt = acc_r;
      endcase
    end

    if (cmd.rem_clr) begin
      rem_nxt = '0;
    end

    if (cmd.div_step) begin
      word_nxt = {word_r[W-2:0], 1'b0};
      if (div_t >= {1'b0, range_r}) begin
        rem_nxt = W'(div_t - {1'b0, range_r});
      end else begin
        rem_nxt = div_t[W-1:0];
      end
    end

    if (cmd.load_out) begin
      priority if (kind_r == pcg_rxs_pkg::KIND_RAW) begin
        value_nxt = word_r;
        err_nxt   = 1'b0;
      end else if (range_zero_r) begin
        value_nxt = min_r;
        err_nxt   = 1'b1;
      end else begin
        value_nxt = min_r + rem_r;
        err_nxt   = 1'b0;
      end
    end
  end

  // generator state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else begin
      state_r <= state_nxt;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    w_r          <= w_nxt;
    acc_r        <= acc_nxt;
    word_r       <= word_nxt;
    rem_r        <= rem_nxt;
    min_r        <= min_nxt;
    range_r      <= range_nxt;
    kind_r       <= kind_nxt;
    range_zero_r <= range_zero_nxt;
    value_r      <= value_nxt;
    err_r        <= err_nxt;
  end

  assign sts.kind        = kind_r;
  assign sts.range_zero  = range_zero_r;
  assign out_value       = value_r;
  assign out_range_error = err_r;

endmodule

// ===== rtl/core/pcg_rxs_ctrl.sv =====
// controller: sequences seeding, the two products, the remainder and the result word
`timescale 1ns / 1ps

module pcg_rxs_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  cfg_we,
  output pcg_rxs_pkg::dp_cmd_t  cmd,
  input  pcg_rxs_pkg::dp_sts_t  sts
);

  localparam logic [pcg_rxs_pkg::DIV_CNT_W-1:0] DIV_LAST =
    pcg_rxs_pkg::DIV_CNT_W'(pcg_rxs_pkg::WORD_W - 1);

  pcg_rxs_pkg::ctrl_state_t             state_r, state_nxt;
  logic                                 seed_run_r, seed_run_nxt;
  logic [pcg_rxs_pkg::DIV_CNT_W-1:0]    div_cnt_r, div_cnt_nxt;
  logic                                 out_valid_r, out_valid_nxt;

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pcg_rxs_pkg::ST_IDLE;
      seed_run_r  <= 1'b0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seed_run_r  <= seed_run_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    seed_run_nxt  = seed_run_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;

    unique case (state_r)
      pcg_rxs_pkg::ST_IDLE: begin
        in_ready = !cfg_we;
        if (cfg_we) begin
          cmd.seed_ld  = 1'b1;
          seed_run_nxt = 1'b1;
          state_nxt    = pcg_rxs_pkg::ST_LCG_LL;
        end else if (in_valid) begin
          cmd.accept   = 1'b1;
          seed_run_nxt = 1'b0;
          state_nxt    = pcg_rxs_pkg::ST_LCG_LL;
        end
      end
      pcg_rxs_pkg::ST_LCG_LL: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_phase = pcg_rxs_pkg::MP_LL;
        cmd.mul_src   = pcg_rxs_pkg::SRC_LCG;
        state_nxt     = pcg_rxs_pkg::ST_LCG_HL;
      end
      pcg_rxs_pkg::ST_LCG_HL: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_phase = pcg_rxs_pkg::MP_HL;
        cmd.mul_src   = pcg_rxs_pkg::SRC_LCG;
        state_nxt     = pcg_rxs_pkg::ST_LCG_LH;
      end
      pcg_rxs_pkg::ST_LCG_LH: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_phase = pcg_rxs_pkg::MP_LH;
        cmd.mul_src   = pcg_rxs_pkg::SRC_LCG;
        state_nxt     = seed_run_r ? pcg_rxs_pkg::ST_IDLE : pcg_rxs_pkg::ST_OUT_LL;
      end
      pcg_rxs_pkg::ST_OUT_LL: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_phase = pcg_rxs_pkg::MP_LL;
        cmd.mul_src   = pcg_rxs_pkg::SRC_OUT;
        state_nxt     = pcg_rxs_pkg::ST_OUT_HL;
      end
      pcg_rxs_pkg::ST_OUT_HL: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_phase = pcg_rxs_pkg::MP_HL;
        cmd.mul_src   = pcg_rxs_pkg::SRC_OUT;
        state_nxt     = pcg_rxs_pkg::ST_OUT_LH;
      end
      pcg_rxs_pkg::ST_OUT_LH: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_phase = pcg_rxs_pkg::MP_LH;
        cmd.mul_src   = pcg_rxs_pkg::SRC_OUT;
        if (sts.kind == pcg_rxs_pkg::KIND_UNIFORM && !sts.range_zero) begin
          cmd.rem_clr = 1'b1;
          div_cnt_nxt = '0;
          state_nxt   = pcg_rxs_pkg::ST_DIV;
        end else begin
          state_nxt   = pcg_rxs_pkg::ST_FIN;
        end
      end
      pcg_rxs_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_LAST) begin
          state_nxt = pcg_rxs_pkg::ST_FIN;
        end
      end
      pcg_rxs_pkg::ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = pcg_rxs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pcg_rxs_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  // an accepted word starts the state advance, not a seeding run
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == pcg_rxs_pkg::ST_LCG_LL && !seed_run_r))
    else $error("accepted word did not start the state advance");

  // the result register is never overwritten while still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result register loaded while still held");

  // remainder steps only run for a uniform word with a nonzero range
  a_div_only_uniform: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pcg_rxs_pkg::ST_DIV) |-> (sts.kind && !sts.range_zero))
    else $error("remainder running for a raw or zero-range word");

  // a seeding run ends after the state advance without a result
  a_seed_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pcg_rxs_pkg::ST_LCG_LH && seed_run_r) |=>
      (state_r == pcg_rxs_pkg::ST_IDLE && !cmd.load_out))
    else $error("seeding run did not return to idle");

endmodule

// ===== rtl/core/pcg_rxs_m_xs_random_generator_top.sv =====
// top level of the pcg rxs-m-xs 64-bit random generator
// each word runs the lcg and output products, three partial products each on the shared 32x32
//   multiplier; a uniform word with a nonzero range then runs the bit-serial remainder; these set
//   the rate. The result loads once the last one is taken; a new word is accepted after that load
// a seed write keeps the request side busy while the state advances once
// reset (synchronous, active low) clears the generator state to zero and empties the result stage
`timescale 1ns / 1ps

module pcg_rxs_m_xs_random_generator_top (
  input  logic                            clk,
  input  logic                            rst_n,
  pcg_rxs_req_if.sink                     in_ch,
  pcg_rxs_rsp_if.source                   out_ch,
  input  logic                            cfg_we,
  input  logic [pcg_rxs_pkg::WORD_W-1:0]  cfg_wdata
);

  pcg_rxs_pkg::dp_cmd_t cmd;
  pcg_rxs_pkg::dp_sts_t sts;

  // sequencer
  pcg_rxs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cfg_we    (cfg_we),
    .cmd       (cmd),
    .sts       (sts)
  );

  // arithmetic and storage
  pcg_rxs_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_kind         (in_ch.kind),
    .in_min_value    (in_ch.min_value),
    .in_max_value    (in_ch.max_value),
    .cfg_wdata       (cfg_wdata),
    .out_value       (out_ch.value),
    .out_range_error (out_ch.range_error)
  );

endmodule
